// File: sv/spu_pkg.sv
package spu_pkg;

	// quotient bits kept below the clamp point (clamp at 2^40)
	localparam int QW = 41;
	// restoring steps per divider stage
	localparam int DIV_STEPS = 3;
	localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
	// width of the unsaturated sums
	localparam int WW = 44;

	typedef enum logic {
		OP_PROJECT   = 1'b0,
		OP_UNPROJECT = 1'b1
	} op_t;

	localparam logic [2:0] REG_FOCAL_X  = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_BF       = 3'd4;
	localparam logic [2:0] REG_STEREO   = 3'd5;
	localparam logic [2:0] REG_X_BOUNDS = 3'd6;
	localparam logic [2:0] REG_Y_BOUNDS = 3'd7;

	// one divider lane in flight
	typedef struct packed {
		logic [32:0]   rem;
		logic [31:0]   den;
		logic [QW-1:0] nlo;
		logic [QW-1:0] q;
		logic          dz;
		logic          nnz;
		logic          ovf;
		logic          neg;
	} lane_t;

	// item data that rides alongside the dividers
	typedef struct packed {
		op_t         op;
		logic [31:0] z;
	} side_t;

endpackage

// File: sv/spu_req_if.sv
interface spu_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] coord_first;
	logic [31:0] coord_second;
	logic [31:0] depth;

	modport source (output valid, opcode, coord_first, coord_second, depth, input ready);
	modport sink (input valid, opcode, coord_first, coord_second, depth, output ready);
endinterface

// File: sv/spu_rsp_if.sv
interface spu_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_first;
	logic [31:0] result_second;
	logic [31:0] result_third;
	logic        in_view;

	modport source (output valid, result_first, result_second, result_third, in_view,
		input ready);
	modport sink (input valid, result_first, result_second, result_third, in_view,
		output ready);
endinterface

// File: sv/stereo_pinhole_project_unproject.sv
// Request beats pass stage 1, stage 2, the divider setup stage, the divider stages, stage 4 and the output register.
// Throughput: one beat per cycle while the output register is empty or taken; the three 64/32 dividers are restoring
// dividers unrolled at three quotient bits per pipeline stage.
// The whole pipe advances when the output register is empty or taken.
// arst_n clears valid bits and loads the calibration registers' defaults.
module stereo_pinhole_project_unproject #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	spu_req_if.sink           req,
	spu_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import spu_pkg::*;

	localparam logic [QW-1:0] LIM = QW'(1) << (QW - 1);

	// calibration registers
	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q, bf_q;
	logic        stereo_q;
	logic [63:0] xb_q, yb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 32'd32768000;
			focal_y_q  <= 32'd32768000;
			center_x_q <= 32'd20971520;
			center_y_q <= 32'd15728640;
			bf_q       <= '0;
			stereo_q   <= 1'b0;
			xb_q       <= 64'h0280_0000_0000_0000;
			yb_q       <= 64'h01E0_0000_0000_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:  focal_x_q  <= cfg_data[31:0];
				REG_FOCAL_Y:  focal_y_q  <= cfg_data[31:0];
				REG_CENTER_X: center_x_q <= cfg_data[31:0];
				REG_CENTER_Y: center_y_q <= cfg_data[31:0];
				REG_BF:       bf_q       <= cfg_data[31:0];
				REG_STEREO:   stereo_q   <= cfg_data[0];
				REG_X_BOUNDS: xb_q       <= cfg_data;
				REG_Y_BOUNDS: yb_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic val_q;
	assign adv = !val_q || rsp.ready;
	assign req.ready = adv;

	// stage 1: magnitudes, signs, multiplier operand select
	logic        v_s1;
	side_t       sd_s1;
	logic [32:0] a0_s1, a1_s1;
	logic [31:0] b0_s1, b1_s1, mz_s1;
	logic        neg0_s1, neg1_s1, neg2_s1;

	logic signed [33:0] du, dv;
	logic [32:0] mdu, mdv;
	logic [31:0] ma, mb, mz;
	logic        is_un;
	always_comb begin
		is_un = (req.opcode == OP_UNPROJECT);
		du  = 34'(signed'(req.coord_first)) - signed'({2'b00, center_x_q});
		dv  = 34'(signed'(req.coord_second)) - signed'({2'b00, center_y_q});
		mdu = du[33] ? 33'(-du) : du[32:0];
		mdv = dv[33] ? 33'(-dv) : dv[32:0];
		ma  = req.coord_first[31] ? 32'(-req.coord_first) : req.coord_first;
		mb  = req.coord_second[31] ? 32'(-req.coord_second) : req.coord_second;
		mz  = req.depth[31] ? 32'(-req.depth) : req.depth;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= req.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.op <= op_t'(req.opcode);
			sd_s1.z  <= req.depth;
			mz_s1    <= mz;
			a0_s1    <= is_un ? mdu : {1'b0, focal_x_q};
			b0_s1    <= is_un ? mz : ma;
			a1_s1    <= is_un ? mdv : {1'b0, focal_y_q};
			b1_s1    <= is_un ? mz : mb;
			neg0_s1  <= (is_un ? du[33] : req.coord_first[31]) ^ req.depth[31];
			neg1_s1  <= (is_un ? dv[33] : req.coord_second[31]) ^ req.depth[31];
			neg2_s1  <= req.depth[31];
		end
	end

	// stage 2: products
	logic        v_s2;
	side_t       sd_s2;
	logic [63:0] n0_s2, n1_s2, n2_s2;
	logic [31:0] d0_s2, d1_s2, d2_s2;
	logic        neg0_s2, neg1_s2, neg2_s2;
	logic [64:0] p0, p1;
	assign p0 = 65'(a0_s1) * 65'(b0_s1);
	assign p1 = 65'(a1_s1) * 65'(b1_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s2   <= sd_s1;
			n0_s2   <= p0[63:0];
			n1_s2   <= p1[63:0];
			n2_s2   <= 64'(bf_q) << FRAC_BITS;
			d0_s2   <= (sd_s1.op == OP_UNPROJECT) ? focal_x_q : mz_s1;
			d1_s2   <= (sd_s1.op == OP_UNPROJECT) ? focal_y_q : mz_s1;
			d2_s2   <= mz_s1;
			neg0_s2 <= neg0_s1;
			neg1_s2 <= neg1_s1;
			neg2_s2 <= neg2_s1;
		end
	end

	function automatic lane_t lane_init(logic [63:0] n, logic [31:0] d, logic ng);
		lane_t l;
		l.den = d;
		l.nlo = n[QW-1:0];
		l.q   = '0;
		l.rem = 33'(n[63:QW]);
		l.dz  = (d == '0);
		l.nnz = (n != '0);
		l.ovf = (33'(n[63:QW]) >= {1'b0, d});
		l.neg = ng;
		return l;
	endfunction

	function automatic lane_t lane_step(lane_t l, logic [5:0] j);
		logic [32:0] r;
		r = {l.rem[31:0], l.nlo[j]};
		if (r >= {1'b0, l.den}) begin
			r = r - {1'b0, l.den};
			l.q[j] = 1'b1;
		end
		l.rem = r;
		return l;
	endfunction

	function automatic logic signed [WW-1:0] lane_val(lane_t l);
		logic [QW-1:0] m;
		if (l.dz) m = l.nnz ? LIM : '0;
		else if (l.ovf || l.q > LIM) m = LIM;
		else m = l.q;
		return l.neg ? -signed'(WW'(m)) : signed'(WW'(m));
	endfunction

	// divider stages: index 0 is the setup stage
	lane_t ln_s [0:DIV_STAGES][0:2];
	side_t sd_s [0:DIV_STAGES];
	logic  vd_s [0:DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_s[0] <= 1'b0;
		else if (adv) vd_s[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0]    <= sd_s2;
			ln_s[0][0] <= lane_init(n0_s2, d0_s2, neg0_s2);
			ln_s[0][1] <= lane_init(n1_s2, d1_s2, neg1_s2);
			ln_s[0][2] <= lane_init(n2_s2, d2_s2, neg2_s2);
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		lane_t nx [0:2];
		always_comb begin
			for (int c = 0; c < 3; c++) begin
				nx[c] = ln_s[k-1][c];
				for (int m = 0; m < DIV_STEPS; m++) begin
					if ((k - 1) * DIV_STEPS + m < QW)
						nx[c] = lane_step(nx[c], 6'(QW - 1 - ((k - 1) * DIV_STEPS + m)));
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_s[k] <= 1'b0;
			else if (adv) vd_s[k] <= vd_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sd_s[k] <= sd_s[k-1];
				for (int c = 0; c < 3; c++) ln_s[k][c] <= nx[c];
			end
		end
	end

	// stage 4: signed quotients, plus center for projection
	logic                 v_s4;
	side_t                sd_s4;
	logic signed [WW-1:0] u_s4, w_s4, q2_s4;
	logic signed [WW-1:0] q0, q1;
	assign q0 = lane_val(ln_s[DIV_STAGES][0]);
	assign q1 = lane_val(ln_s[DIV_STAGES][1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= vd_s[DIV_STAGES];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s4 <= sd_s[DIV_STAGES];
			q2_s4 <= lane_val(ln_s[DIV_STAGES][2]);
			if (sd_s[DIV_STAGES].op == OP_UNPROJECT) begin
				u_s4 <= q0;
				w_s4 <= q1;
			end else begin
				u_s4 <= q0 + signed'(WW'(center_x_q));
				w_s4 <= q1 + signed'(WW'(center_y_q));
			end
		end
	end

	function automatic logic [31:0] sat32(logic signed [WW-1:0] x);
		if (x > signed'(WW'(32'h7FFF_FFFF))) return 32'h7FFF_FFFF;
		if (x < -signed'(WW'(33'h0_8000_0000))) return 32'h8000_0000;
		return x[31:0];
	endfunction

	// stage 5: right column, bounds, saturation into the output register
	logic signed [WW-1:0] third;
	logic                 inb;
	logic [31:0]          rf_q, rs_q, rt_q;
	logic                 iv_q;
	always_comb begin
		third = stereo_q ? (u_s4 - q2_s4) : -signed'(WW'(1) << FRAC_BITS);
		inb = !sd_s4.z[31] && (sd_s4.z != '0)
			&& u_s4 >= WW'(signed'(xb_q[31:0])) && u_s4 <= WW'(signed'(xb_q[63:32]))
			&& w_s4 >= WW'(signed'(yb_q[31:0])) && w_s4 <= WW'(signed'(yb_q[63:32]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) val_q <= 1'b0;
		else if (adv) val_q <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rf_q <= sat32(u_s4);
			rs_q <= sat32(w_s4);
			if (sd_s4.op == OP_UNPROJECT) begin
				rt_q <= sd_s4.z;
				iv_q <= 1'b1;
			end else begin
				rt_q <= sat32(third);
				iv_q <= inb;
			end
		end
	end

	assign rsp.valid         = val_q;
	assign rsp.result_first  = rf_q;
	assign rsp.result_second = rs_q;
	assign rsp.result_third  = rt_q;
	assign rsp.in_view       = iv_q;

endmodule

// File: sv/spu_chk.sv
module spu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_first,
	input logic [31:0] rsp_third,
	input logic        rsp_in_view
);
	// a stalled response beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first)
			&& $stable(rsp_third) && $stable(rsp_in_view))
		else $error("response beat changed while stalled");

	// pipe never stalls intake while the sink takes beats
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("intake blocked with sink ready");

	// empty output register never blocks intake
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("intake blocked with empty output");

	// nothing comes out right after reset
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("response valid out of reset");
endmodule

bind stereo_pinhole_project_unproject spu_chk u_spu_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_first  (rsp.result_first),
	.rsp_third  (rsp.result_third),
	.rsp_in_view(rsp.in_view)
);

// File: sim/spu_tb_if.sv
`timescale 1ns / 100ps

// Testbench copies of the two channels are the RTL's interfaces; nothing extra needed here.
// This file holds a small beat record used by the checker.
package spu_tb_pkg;
	typedef struct {
		logic [31:0] first;
		logic [31:0] second;
		logic [31:0] third;
		logic        view;
	} pixel_beat_t;
endpackage

// File: sim/spu_checker.sv
`timescale 1ns / 100ps

module spu_checker (
	input  logic        clk,
	input  logic        arst_n,
	spu_req_if          req,
	spu_rsp_if          rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import spu_pkg::*;
	import spu_tb_pkg::*;

	localparam longint LIM = 64'sd1 << 40;

	logic [31:0] fx, fy, cx, cy, bf;
	logic        stereo;
	logic [63:0] xb, yb;
	pixel_beat_t expected_q[$];

	// signed quotient of magnitudes, clamped at 2^40; zero divisor gives the clamp value, or zero for a zero numerator
	function automatic longint clamp_quot(input bit neg, input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] m;
		if (den == 0)
			m = (num == 0) ? 0 : LIM;
		else
			m = num / den;
		if (m > LIM)
			m = LIM;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] sat32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic pixel_beat_t map_point(input op_t op, input logic [31:0] a32,
		input logic [31:0] b32, input logic [31:0] z32);
		pixel_beat_t r;
		longint a, b, z, u, v, t, du, dv;
		a = longint'(signed'(a32));
		b = longint'(signed'(b32));
		z = longint'(signed'(z32));
		if (op == OP_PROJECT) begin
			u = clamp_quot((a < 0) != (z < 0), fx * mag(a), mag(z)) + longint'(cx);
			v = clamp_quot((b < 0) != (z < 0), fy * mag(b), mag(z)) + longint'(cy);
			if (stereo)
				t = u - clamp_quot(z < 0, {16'd0, bf, 16'd0}, mag(z));
			else
				t = -(64'sd1 << 16);
			r.first = sat32(u);
			r.second = sat32(v);
			r.third = sat32(t);
			r.view = z > 0 && u >= longint'(signed'(xb[31:0]))
				&& u <= longint'(signed'(xb[63:32]))
				&& v >= longint'(signed'(yb[31:0])) && v <= longint'(signed'(yb[63:32]));
		end else begin
			du = a - longint'(cx);
			dv = b - longint'(cy);
			r.first = sat32(clamp_quot((du < 0) != (z < 0), mag(du) * mag(z), fx));
			r.second = sat32(clamp_quot((dv < 0) != (z < 0), mag(dv) * mag(z), fy));
			r.third = z32;
			r.view = 1'b1;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	// calibration shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx <= 32768000; fy <= 32768000; cx <= 20971520; cy <= 15728640;
			bf <= 0; stereo <= 0;
			xb <= 64'h0280000000000000; yb <= 64'h01E0000000000000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:  fx <= cfg_data[31:0];
				REG_FOCAL_Y:  fy <= cfg_data[31:0];
				REG_CENTER_X: cx <= cfg_data[31:0];
				REG_CENTER_Y: cy <= cfg_data[31:0];
				REG_BF:       bf <= cfg_data[31:0];
				REG_STEREO:   stereo <= cfg_data[0];
				REG_X_BOUNDS: xb <= cfg_data;
				REG_Y_BOUNDS: yb <= cfg_data;
				default: ;
			endcase
		end
	end

	// predict on request beats, compare on response beats
	initial fail_count = 0;
	always @(posedge clk) begin
		pixel_beat_t w;
		if (arst_n && req.valid && req.ready)
			expected_q.push_back(map_point(op_t'(req.opcode), req.coord_first,
				req.coord_second, req.depth));
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected beat", rsp.result_first, 32'd0);
			end else begin
				w = expected_q.pop_front();
				if (rsp.result_first !== w.first) report("first", rsp.result_first, w.first);
				if (rsp.result_second !== w.second)
					report("second", rsp.result_second, w.second);
				if (rsp.result_third !== w.third) report("third", rsp.result_third, w.third);
				if (rsp.in_view !== w.view) report("in_view", rsp.in_view, w.view);
			end
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import spu_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = REG_FOCAL_X;
	logic [63:0] cfg_data = 0;
	int          fail_count, pending;
	int          cycles = 0;
	bit          ready_hold = 0;

	spu_req_if req();
	spu_rsp_if rsp();

	stereo_pinhole_project_unproject uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	spu_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		req.valid = 0; req.opcode = OP_PROJECT;
		req.coord_first = 0; req.coord_second = 0; req.depth = 0;
		rsp.ready = 0;
	end

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAIL stereo_pinhole_project_unproject");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// response stall: ready is drawn anew each clock, mostly high, and held high while ready_hold is set
	always @(posedge clk) begin
		int g;
		if (ready_hold) begin
			rsp.ready <= 1;
		end else begin
			g = gap_len();
			rsp.ready <= (g == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// the checker logs the last beat at this same edge, so step past it before polling pending
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// one beat; when flat is set there is no gap before it
	task automatic send_point(input op_t op, input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] z, input bit flat);
		int g;
		g = flat ? 0 : gap_len();
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1; req.opcode <= op;
		req.coord_first <= a; req.coord_second <= b; req.depth <= z;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
			2: return 32'($urandom_range(0, 2000)) << 16;
			3: return -(32'($urandom_range(0, 2000)) << 16);
			4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : 32'hffffffff;
		endcase
	endfunction

	// mostly a point in front of the camera, near the view cone, to project or unproject; now and then arbitrary values
	task automatic send_random(input bit flat);
		logic [31:0] z;
		if ($urandom_range(0, 3) != 0) begin
			z = (32'($urandom_range(1, 200)) << 16) | 32'($urandom_range(0, 65535));
			if ($urandom_range(0, 1))
				send_point(OP_PROJECT, 32'(signed'($urandom_range(0, 1000)) - 500) *
					32'($urandom_range(1, 200)) << 8, 32'(signed'($urandom_range(0, 800)) - 400) *
					32'($urandom_range(1, 200)) << 8, z, flat);
			else
				send_point(OP_UNPROJECT, 32'($urandom_range(0, 700)) << 16 | 16'($urandom),
					32'($urandom_range(0, 500)) << 16 | 16'($urandom), z, flat);
		end else begin
			send_point(op_t'($urandom_range(0, 1)), pick_val(), pick_val(), pick_val(), flat);
		end
	endtask

	initial begin
		int n;
		bit flat;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default calibration
		send_point(OP_PROJECT, 0, 0, 32'h00010000, 0);
		send_point(OP_PROJECT, 32'h7fffffff, 32'h80000000, 32'h00000001, 0);
		send_point(OP_PROJECT, 32'h00010000, 32'hffff0000, 0, 0);
		send_point(OP_PROJECT, 0, 0, 0, 0);
		send_point(OP_PROJECT, 32'h00010000, 32'h00010000, 32'hffff0000, 0);
		send_point(OP_PROJECT, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		send_point(OP_PROJECT, -(32'd320 << 16), -(32'd240 << 16), 32'd500 << 16, 0);
		send_point(OP_PROJECT, 32'd320 << 16, 32'd240 << 16, 32'd500 << 16, 0);
		send_point(OP_PROJECT, 32'd321 << 16, 0, 32'd500 << 16, 0);
		send_point(OP_UNPROJECT, 32'd320 << 16, 32'd240 << 16, 32'd5 << 16, 0);
		send_point(OP_UNPROJECT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
		send_point(OP_UNPROJECT, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		send_point(OP_UNPROJECT, 0, 0, 0, 0);
		req.valid <= 0;
		drain();

		// stereo, extreme calibration
		write_reg(REG_STEREO, 1);
		write_reg(REG_BF, 32'd60 << 16);
		send_point(OP_PROJECT, 32'h00010000, 32'h00010000, 32'd2 << 16, 0);
		send_point(OP_PROJECT, 32'h00010000, 32'h00010000, 0, 0);
		req.valid <= 0;
		drain();
		write_reg(REG_BF, 32'hffffffff);
		write_reg(REG_FOCAL_X, 32'hffffffff);
		write_reg(REG_FOCAL_Y, 1);
		write_reg(REG_CENTER_X, 32'hffffffff);
		write_reg(REG_CENTER_Y, 0);
		write_reg(REG_X_BOUNDS, 64'h7fffffff80000000);
		write_reg(REG_Y_BOUNDS, 64'h8000000000000000);
		send_point(OP_PROJECT, 32'h7fffffff, 32'h00010000, 32'h00000001, 0);
		send_point(OP_PROJECT, 32'h00000001, 32'h00000001, 32'h7fffffff, 0);
		send_point(OP_UNPROJECT, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
		send_point(OP_UNPROJECT, 32'h7fffffff, 32'h80000000, 32'h80000000, 0);
		req.valid <= 0;
		drain();

		// random phases, cycling through four calibration setups
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin
					write_reg(REG_FOCAL_X, 32'd500 << 16);
					write_reg(REG_FOCAL_Y, 32'd500 << 16);
					write_reg(REG_CENTER_X, 32'd320 << 16);
					write_reg(REG_CENTER_Y, 32'd240 << 16);
					write_reg(REG_X_BOUNDS, 64'h0280000000000000);
					write_reg(REG_Y_BOUNDS, 64'h01E0000000000000);
				end
				1: begin
					write_reg(REG_FOCAL_X, 32'($urandom_range(1, 2000)) << 16 | 16'($urandom));
					write_reg(REG_FOCAL_Y, 32'($urandom_range(1, 2000)) << 16 | 16'($urandom));
					write_reg(REG_CENTER_X, 32'($urandom_range(0, 1000)) << 16);
					write_reg(REG_CENTER_Y, 32'($urandom_range(0, 1000)) << 16);
					write_reg(REG_X_BOUNDS, {32'($urandom_range(200, 900)) << 16,
						32'($urandom_range(0, 200)) << 16});
					write_reg(REG_Y_BOUNDS, {32'($urandom_range(200, 900)) << 16,
						-(32'($urandom_range(0, 200)) << 16)});
				end
				2: begin
					write_reg(REG_FOCAL_X, 1);
					write_reg(REG_FOCAL_Y, 32'hffffffff);
					write_reg(REG_X_BOUNDS, {$urandom, $urandom});
					write_reg(REG_Y_BOUNDS, {$urandom, $urandom});
				end
				default: begin
					write_reg(REG_FOCAL_X, $urandom);
					write_reg(REG_FOCAL_Y, $urandom | 1);
					write_reg(REG_CENTER_X, $urandom);
					write_reg(REG_CENTER_Y, $urandom);
				end
			endcase
			write_reg(REG_STEREO, ph[0] ^ ph[2]);
			write_reg(REG_BF, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 100)) << 16);
			n = 0;
			while (n < 250) begin
				flat = (ph == 3);
				send_random(flat);
				n++;
				// hold off until the pipe is empty once per phase
				if (n == 120) begin
					req.valid <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			req.valid <= 0;
			ready_hold = (ph == 5);
			drain();
		end

		drain();
		if (fail_count == 0)
			$display("PASS stereo_pinhole_project_unproject");
		else
			$display("FAIL stereo_pinhole_project_unproject");
		$finish;
	end

endmodule

// File: stereo_pinhole_project_unproject.f
sv/spu_pkg.sv
sv/spu_req_if.sv
sv/spu_rsp_if.sv
sv/stereo_pinhole_project_unproject.sv
sv/spu_chk.sv
sim/spu_tb_if.sv
sim/spu_checker.sv
sim/testbench.sv
